### src/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and codes for the order book matcher: report status codes,
// datapath operations and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package lobm_pkg;

    typedef enum logic [2:0] {
        ST_FILL      = 3'd0,
        ST_FILLED    = 3'd1,
        ST_IOC       = 3'd2,
        ST_RESTING   = 3'd3,
        ST_PARTIAL   = 3'd4,
        ST_CANCELLED = 3'd5,
        ST_NOT_FOUND = 3'd6,
        ST_BOOK_FULL = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN_START,
        OP_SCAN_STEP,
        OP_RD_HT,
        OP_LATCH_HT,
        OP_FILL,
        OP_SET_ST,
        OP_ALLOC_RD,
        OP_INS_WR,
        OP_INS_LINK,
        OP_CLV_INC,
        OP_NODE,
        OP_EMIT_FIN
    } dp_op_t;

    typedef enum logic [1:0] {
        SCAN_OPP,
        SCAN_OWN,
        SCAN_ALL
    } scan_mode_t;

    typedef struct packed {
        dp_op_t     op;
        scan_mode_t mode;
        status_t    st;
    } dp_cmd_t;

    typedef struct packed {
        logic in_cancel;
        logic out_free;
        logic rem_zero;
        logic cap_hit;
        logic market;
        logic opp_go;
        logic scan_last;
        logic ins_ok;
        logic has_match;
        logic clv_end;
        logic clv_valid;
        logic node_hit;
        logic node_tail;
    } dp_stat_t;

endpackage

### src/lobm_ram.sv
// ----------------------------------------------------------------------------
// lobm_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while rd_en is low.
// ----------------------------------------------------------------------------
module lobm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### src/lobm_datapath.sv
// ----------------------------------------------------------------------------
// lobm_datapath
// Book storage and arithmetic: level table, slot store, free-slot stack,
// level scan unit, fill arithmetic and the output record register.
// ----------------------------------------------------------------------------
module lobm_datapath #(
    parameter int ORDER_SLOTS     = 1024,
    parameter int LEVELS_PER_SIDE = 64,
    parameter int MAX_FILLS       = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lobm_pkg::dp_cmd_t cmd,
    output lobm_pkg::dp_stat_t stat,
    input  logic              req_type,
    input  logic              side,
    input  logic              mkt,
    input  logic [31:0]       price,
    input  logic [31:0]       qty,
    input  logic [63:0]       client_order_id,
    input  logic [31:0]       eng_id,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic [31:0]       fill_price,
    output logic [31:0]       quantity,
    output logic [63:0]       maker_client_id,
    output logic [31:0]       maker_eng_id,
    output logic [31:0]       maker_left,
    output logic [6:0]        num_fills,
    output logic              has_bid,
    output logic [31:0]       bid_px,
    output logic              has_ask,
    output logic [31:0]       ask_px,
    output logic              last
);

    import lobm_pkg::*;

    localparam int SLOT_W     = $clog2(ORDER_SLOTS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int ALL_LEVELS = 2 * LEVELS_PER_SIDE;
    localparam int LVL_W      = $clog2(ALL_LEVELS);
    localparam logic [LVL_W-1:0] LPS_IDX  = LVL_W'(LEVELS_PER_SIDE);
    localparam logic [LVL_W-1:0] SPAN     = LVL_W'(LEVELS_PER_SIDE - 1);
    localparam logic [LVL_W-1:0] LAST_IDX = LVL_W'(ALL_LEVELS - 1);
    localparam logic [LVL_W:0]   CLV_END  = (LVL_W + 1)'(ALL_LEVELS);
    localparam logic [CNT_W-1:0] SLOTS_N  = CNT_W'(ORDER_SLOTS);
    localparam logic [6:0]       CAP      = 7'(MAX_FILLS);

    // request
    logic        req_type_reg, side_reg, market_reg;
    logic [31:0] price_reg, oid_reg, rem_reg;
    logic [63:0] cid_reg;
    logic [6:0]  count_reg;
    status_t     st_reg;

    // scan unit
    logic [LVL_W-1:0] scan_idx_reg, scan_hi_reg;
    logic             bid_f_reg, ask_f_reg, match_f_reg, free_f_reg;
    logic [LVL_W-1:0] bid_lv_reg, ask_lv_reg, match_lv_reg, free_lv_reg;
    logic [31:0]      bid_p_reg, ask_p_reg;

    logic [ALL_LEVELS-1:0] lvl_valid_reg;
    logic [LVL_W-1:0]      cur_lv_reg;
    logic [LVL_W:0]        clv_reg;
    logic [SLOT_W-1:0]     s_reg, prev_reg, head_reg, tail_reg, new_s_reg;
    logic                  first_reg;
    logic [CNT_W-1:0]      sp_reg, fresh_reg;
    logic                  out_valid_reg;

    logic [2:0]  o_status_reg;
    logic [31:0] o_fp_reg, o_qty_reg, o_moid_reg, o_ml_reg, o_bb_reg, o_ba_reg;
    logic [63:0] o_mcid_reg;
    logic [6:0]  o_fc_reg;
    logic        o_hb_reg, o_ha_reg, o_last_reg;

    // RAM ports
    logic              pr_we, pr_re, hd_we, hd_re, tl_we, tl_re;
    logic [LVL_W-1:0]  pr_wa, pr_ra, hd_wa, hd_ra, tl_wa, tl_ra;
    logic [31:0]       pr_rd;
    logic [SLOT_W-1:0] hd_wd, hd_rd, tl_wd, tl_rd;
    logic              in_we, qt_we, nx_we, sl_re, fs_we, fs_re;
    logic [SLOT_W-1:0] in_wa, qt_wa, nx_wa, sl_ra, fs_wa, fs_ra, nx_wd, nx_rd;
    logic [SLOT_W-1:0] fs_wd, fs_rd;
    logic [95:0]       in_wd, in_rd;
    logic [31:0]       qt_wd, qt_rd;

    lobm_ram #(.WIDTH(32), .DEPTH(ALL_LEVELS)) u_lvl_price (
        .clk(clk), .wr_en(pr_we), .wr_addr(pr_wa), .wr_data(price_reg),
        .rd_en(pr_re), .rd_addr(pr_ra), .rd_data(pr_rd));
    lobm_ram #(.WIDTH(SLOT_W), .DEPTH(ALL_LEVELS)) u_lvl_head (
        .clk(clk), .wr_en(hd_we), .wr_addr(hd_wa), .wr_data(hd_wd),
        .rd_en(hd_re), .rd_addr(hd_ra), .rd_data(hd_rd));
    lobm_ram #(.WIDTH(SLOT_W), .DEPTH(ALL_LEVELS)) u_lvl_tail (
        .clk(clk), .wr_en(tl_we), .wr_addr(tl_wa), .wr_data(tl_wd),
        .rd_en(tl_re), .rd_addr(tl_ra), .rd_data(tl_rd));
    lobm_ram #(.WIDTH(96), .DEPTH(ORDER_SLOTS)) u_slot_info (
        .clk(clk), .wr_en(in_we), .wr_addr(in_wa), .wr_data(in_wd),
        .rd_en(sl_re), .rd_addr(sl_ra), .rd_data(in_rd));
    lobm_ram #(.WIDTH(32), .DEPTH(ORDER_SLOTS)) u_slot_qty (
        .clk(clk), .wr_en(qt_we), .wr_addr(qt_wa), .wr_data(qt_wd),
        .rd_en(sl_re), .rd_addr(sl_ra), .rd_data(qt_rd));
    lobm_ram #(.WIDTH(SLOT_W), .DEPTH(ORDER_SLOTS)) u_slot_next (
        .clk(clk), .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
        .rd_en(sl_re), .rd_addr(sl_ra), .rd_data(nx_rd));
    lobm_ram #(.WIDTH(SLOT_W), .DEPTH(ORDER_SLOTS)) u_free_stack (
        .clk(clk), .wr_en(fs_we), .wr_addr(fs_wa), .wr_data(fs_wd),
        .rd_en(fs_re), .rd_addr(fs_ra), .rd_data(fs_rd));

    logic [LVL_W-1:0]  scan_lo, scan_hi, opp_lv, ht_lv;
    logic              opp_f, is_ask, scan_v, out_free;
    logic [31:0]       opp_p, fq, ml;
    logic [SLOT_W-1:0] alloc_s;
    logic [31:0]       eid_rd;

    assign eid_rd  = in_rd[95:64];
    assign opp_f   = side_reg ? bid_f_reg : ask_f_reg;
    assign opp_p   = side_reg ? bid_p_reg : ask_p_reg;
    assign opp_lv  = side_reg ? bid_lv_reg : ask_lv_reg;
    assign ht_lv   = req_type_reg ? clv_reg[LVL_W-1:0] : opp_lv;
    assign is_ask  = scan_idx_reg >= LPS_IDX;
    assign scan_v  = lvl_valid_reg[scan_idx_reg];
    assign fq      = (rem_reg < qt_rd) ? rem_reg : qt_rd;
    assign ml      = qt_rd - fq;
    assign alloc_s = (sp_reg != '0) ? fs_rd : fresh_reg[SLOT_W-1:0];
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        unique case (cmd.mode)
            SCAN_OPP: scan_lo = side_reg ? '0 : LPS_IDX;
            SCAN_OWN: scan_lo = side_reg ? LPS_IDX : '0;
            default:  scan_lo = '0;
        endcase
        scan_hi = (cmd.mode == SCAN_ALL) ? LAST_IDX : scan_lo + SPAN;
    end

    always_comb
    begin
        stat.in_cancel = req_type;
        stat.out_free  = out_free;
        stat.rem_zero  = rem_reg == '0;
        stat.cap_hit   = count_reg == CAP;
        stat.market    = market_reg;
        stat.opp_go    = opp_f && (market_reg ||
                         (side_reg ? price_reg <= opp_p : price_reg >= opp_p));
        stat.scan_last = scan_idx_reg == scan_hi_reg;
        stat.ins_ok    = (sp_reg != '0 || fresh_reg != SLOTS_N) &&
                         (match_f_reg || free_f_reg);
        stat.has_match = match_f_reg;
        stat.clv_end   = clv_reg == CLV_END;
        stat.clv_valid = lvl_valid_reg[clv_reg[LVL_W-1:0]];
        stat.node_hit  = eid_rd == oid_reg;
        stat.node_tail = s_reg == tail_reg;
    end

    // RAM control
    always_comb
    begin
        pr_we = 1'b0; pr_wa = free_lv_reg;
        pr_re = 1'b0; pr_ra = scan_lo;
        hd_we = 1'b0; hd_wa = cur_lv_reg; hd_wd = nx_rd;
        hd_re = 1'b0; hd_ra = ht_lv;
        tl_we = 1'b0; tl_wa = cur_lv_reg; tl_wd = prev_reg;
        tl_re = 1'b0; tl_ra = ht_lv;
        in_we = 1'b0; in_wa = alloc_s; in_wd = {oid_reg, cid_reg};
        qt_we = 1'b0; qt_wa = s_reg; qt_wd = ml;
        nx_we = 1'b0; nx_wa = prev_reg; nx_wd = nx_rd;
        sl_re = 1'b0; sl_ra = hd_rd;
        fs_we = 1'b0; fs_wa = sp_reg[SLOT_W-1:0]; fs_wd = s_reg;
        fs_re = 1'b0; fs_ra = SLOT_W'(sp_reg - 1'b1);
        unique case (cmd.op)
            OP_SCAN_START: pr_re = 1'b1;
            OP_SCAN_STEP:
            begin
                pr_re = 1'b1;
                pr_ra = scan_idx_reg + 1'b1;
            end
            OP_RD_HT:
            begin
                hd_re = 1'b1;
                tl_re = 1'b1;
            end
            OP_LATCH_HT: sl_re = 1'b1;
            OP_FILL:
            begin
                qt_we = 1'b1;
                if (ml == '0)
                begin
                    fs_we = 1'b1;
                    hd_we = tail_reg != s_reg;
                end
            end
            OP_ALLOC_RD:
            begin
                fs_re = 1'b1;
                tl_re = 1'b1;
                tl_ra = match_lv_reg;
            end
            OP_INS_WR:
            begin
                in_we = 1'b1;
                qt_we = 1'b1;
                qt_wa = alloc_s;
                qt_wd = rem_reg;
                nx_we = 1'b1;
                nx_wa = alloc_s;
                nx_wd = alloc_s;
                tl_we = 1'b1;
                tl_wa = match_f_reg ? match_lv_reg : free_lv_reg;
                tl_wd = alloc_s;
                if (!match_f_reg)
                begin
                    pr_we = 1'b1;
                    hd_we = 1'b1;
                    hd_wa = free_lv_reg;
                    hd_wd = alloc_s;
                end
            end
            OP_INS_LINK:
            begin
                nx_we = 1'b1;
                nx_wa = tail_reg;
                nx_wd = new_s_reg;
            end
            OP_NODE:
            begin
                if (eid_rd == oid_reg)
                begin
                    fs_we = 1'b1;
                    if (head_reg != tail_reg)
                    begin
                        if (first_reg)
                        begin
                            hd_we = 1'b1;
                        end
                        else
                        begin
                            nx_we = 1'b1;
                            tl_we = tail_reg == s_reg;
                        end
                    end
                end
                else if (s_reg != tail_reg)
                begin
                    sl_re = 1'b1;
                    sl_ra = nx_rd;
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_valid_reg <= '0;
            sp_reg        <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new record is only loaded once the previous beat is gone
            if (cmd.op == OP_FILL || cmd.op == OP_EMIT_FIN)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_FILL:
                begin
                    if (ml == '0)
                    begin
                        sp_reg <= sp_reg + 1'b1;
                        if (tail_reg == s_reg)
                        begin
                            lvl_valid_reg[cur_lv_reg] <= 1'b0;
                        end
                    end
                end
                OP_INS_WR:
                begin
                    if (sp_reg != '0)
                    begin
                        sp_reg <= sp_reg - 1'b1;
                    end
                    else
                    begin
                        fresh_reg <= fresh_reg + 1'b1;
                    end
                    if (!match_f_reg)
                    begin
                        lvl_valid_reg[free_lv_reg] <= 1'b1;
                    end
                end
                OP_NODE:
                begin
                    if (eid_rd == oid_reg)
                    begin
                        sp_reg <= sp_reg + 1'b1;
                        if (head_reg == tail_reg)
                        begin
                            lvl_valid_reg[cur_lv_reg] <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                req_type_reg <= req_type;
                side_reg     <= side;
                market_reg   <= mkt;
                price_reg    <= price;
                cid_reg      <= client_order_id;
                oid_reg      <= eng_id;
                rem_reg      <= req_type ? 32'd0 : qty;
                count_reg    <= '0;
                clv_reg      <= '0;
            end
            OP_SCAN_START:
            begin
                scan_idx_reg <= scan_lo;
                scan_hi_reg  <= scan_hi;
                bid_f_reg    <= 1'b0;
                ask_f_reg    <= 1'b0;
                match_f_reg  <= 1'b0;
                free_f_reg   <= 1'b0;
            end
            OP_SCAN_STEP:
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (scan_v)
                begin
                    if (is_ask && (!ask_f_reg || pr_rd < ask_p_reg))
                    begin
                        ask_f_reg  <= 1'b1;
                        ask_lv_reg <= scan_idx_reg;
                        ask_p_reg  <= pr_rd;
                    end
                    if (!is_ask && (!bid_f_reg || pr_rd > bid_p_reg))
                    begin
                        bid_f_reg  <= 1'b1;
                        bid_lv_reg <= scan_idx_reg;
                        bid_p_reg  <= pr_rd;
                    end
                    if (is_ask == side_reg && !match_f_reg && pr_rd == price_reg)
                    begin
                        match_f_reg  <= 1'b1;
                        match_lv_reg <= scan_idx_reg;
                    end
                end
                else if (is_ask == side_reg && !free_f_reg)
                begin
                    free_f_reg  <= 1'b1;
                    free_lv_reg <= scan_idx_reg;
                end
            end
            OP_RD_HT: cur_lv_reg <= ht_lv;
            OP_LATCH_HT:
            begin
                s_reg     <= hd_rd;
                head_reg  <= hd_rd;
                tail_reg  <= tl_rd;
                first_reg <= 1'b1;
            end
            OP_FILL:
            begin
                rem_reg      <= rem_reg - fq;
                count_reg    <= count_reg + 1'b1;
                o_status_reg <= ST_FILL;
                o_fp_reg     <= opp_p;
                o_qty_reg    <= fq;
                o_mcid_reg   <= in_rd[63:0];
                o_moid_reg   <= eid_rd;
                o_ml_reg     <= ml;
                o_fc_reg     <= '0;
                o_hb_reg     <= 1'b0;
                o_bb_reg     <= '0;
                o_ha_reg     <= 1'b0;
                o_ba_reg     <= '0;
                o_last_reg   <= 1'b0;
            end
            OP_SET_ST: st_reg <= cmd.st;
            OP_INS_WR:
            begin
                new_s_reg <= alloc_s;
                tail_reg  <= tl_rd;
                st_reg    <= (count_reg == '0) ? ST_RESTING : ST_PARTIAL;
            end
            OP_CLV_INC: clv_reg <= clv_reg + 1'b1;
            OP_NODE:
            begin
                if (eid_rd == oid_reg)
                begin
                    st_reg  <= ST_CANCELLED;
                    rem_reg <= qt_rd;
                end
                else if (s_reg == tail_reg)
                begin
                    clv_reg <= clv_reg + 1'b1;
                end
                else
                begin
                    prev_reg  <= s_reg;
                    s_reg     <= nx_rd;
                    first_reg <= 1'b0;
                end
            end
            OP_EMIT_FIN:
            begin
                o_status_reg <= st_reg;
                o_fp_reg     <= '0;
                o_qty_reg    <= rem_reg;
                o_mcid_reg   <= '0;
                o_moid_reg   <= '0;
                o_ml_reg     <= '0;
                o_fc_reg     <= count_reg;
                o_hb_reg     <= bid_f_reg;
                o_bb_reg     <= bid_f_reg ? bid_p_reg : 32'd0;
                o_ha_reg     <= ask_f_reg;
                o_ba_reg     <= ask_f_reg ? ask_p_reg : 32'd0;
                o_last_reg   <= 1'b1;
            end
            default: ;
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign status          = o_status_reg;
    assign fill_price      = o_fp_reg;
    assign quantity        = o_qty_reg;
    assign maker_client_id = o_mcid_reg;
    assign maker_eng_id    = o_moid_reg;
    assign maker_left      = o_ml_reg;
    assign num_fills       = o_fc_reg;
    assign has_bid         = o_hb_reg;
    assign bid_px          = o_bb_reg;
    assign has_ask         = o_ha_reg;
    assign ask_px          = o_ba_reg;
    assign last            = o_last_reg;

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= fresh_reg)
        else $error("free stack holds more slots than were ever handed out");

    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FILL) |-> (count_reg < CAP))
        else $error("fill beyond fill cap");

    a_fill_out: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FILL || cmd.op == OP_EMIT_FIN) |-> out_free)
        else $error("record loaded over an untaken beat");

    a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_INS_WR) |-> (sp_reg != '0 || fresh_reg != SLOTS_N))
        else $error("insert with no free slot");

endmodule

### src/lobm_ctrl.sv
// ----------------------------------------------------------------------------
// lobm_ctrl
// Request sequencer: sweep, rest, cancel walk and top-of-book scan, issuing at most
// one datapath operation per cycle and waiting while the output beat is not taken.
// ----------------------------------------------------------------------------
module lobm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lobm_pkg::dp_stat_t stat,
    output lobm_pkg::dp_cmd_t  cmd
);

    import lobm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CHK, S_SCAN, S_BEST, S_HEAD, S_FILL, S_FIN,
        I_SCAN, I_DEC, I_WR, I_LINK,
        T_START, T_SCAN, T_EMIT,
        C_CHK, C_HEAD, C_NODE
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.mode   = SCAN_ALL;
        cmd.st     = ST_FILLED;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = stat.in_cancel ? C_CHK : S_CHK;
                end
            end
            S_CHK:
            begin
                if (stat.rem_zero || stat.cap_hit)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.op     = OP_SCAN_START;
                    cmd.mode   = SCAN_OPP;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN_STEP;
                if (stat.scan_last)
                begin
                    state_next = S_BEST;
                end
            end
            S_BEST:
            begin
                if (stat.opp_go)
                begin
                    cmd.op     = OP_RD_HT;
                    state_next = S_HEAD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_HEAD:
            begin
                cmd.op     = OP_LATCH_HT;
                state_next = S_FILL;
            end
            S_FILL:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_FILL;
                    state_next = S_CHK;
                end
            end
            S_FIN:
            begin
                priority if (stat.rem_zero)
                begin
                    cmd.op     = OP_SET_ST;
                    cmd.st     = ST_FILLED;
                    state_next = T_START;
                end
                else if (stat.market)
                begin
                    cmd.op     = OP_SET_ST;
                    cmd.st     = ST_IOC;
                    state_next = T_START;
                end
                else
                begin
                    cmd.op     = OP_SCAN_START;
                    cmd.mode   = SCAN_OWN;
                    state_next = I_SCAN;
                end
            end
            I_SCAN:
            begin
                cmd.op = OP_SCAN_STEP;
                if (stat.scan_last)
                begin
                    state_next = I_DEC;
                end
            end
            I_DEC:
            begin
                if (stat.ins_ok)
                begin
                    cmd.op     = OP_ALLOC_RD;
                    state_next = I_WR;
                end
                else
                begin
                    cmd.op     = OP_SET_ST;
                    cmd.st     = ST_BOOK_FULL;
                    state_next = T_START;
                end
            end
            I_WR:
            begin
                cmd.op     = OP_INS_WR;
                state_next = stat.has_match ? I_LINK : T_START;
            end
            I_LINK:
            begin
                cmd.op     = OP_INS_LINK;
                state_next = T_START;
            end
            T_START:
            begin
                cmd.op     = OP_SCAN_START;
                cmd.mode   = SCAN_ALL;
                state_next = T_SCAN;
            end
            T_SCAN:
            begin
                cmd.op = OP_SCAN_STEP;
                if (stat.scan_last)
                begin
                    state_next = T_EMIT;
                end
            end
            T_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT_FIN;
                    state_next = S_IDLE;
                end
            end
            C_CHK:
            begin
                priority if (stat.clv_end)
                begin
                    cmd.op     = OP_SET_ST;
                    cmd.st     = ST_NOT_FOUND;
                    state_next = T_START;
                end
                else if (stat.clv_valid)
                begin
                    cmd.op     = OP_RD_HT;
                    state_next = C_HEAD;
                end
                else
                begin
                    cmd.op = OP_CLV_INC;
                end
            end
            C_HEAD:
            begin
                cmd.op     = OP_LATCH_HT;
                state_next = C_NODE;
            end
            C_NODE:
            begin
                cmd.op = OP_NODE;
                priority if (stat.node_hit)
                begin
                    state_next = T_START;
                end
                else if (stat.node_tail)
                begin
                    state_next = C_CHK;
                end
                else
                begin
                    state_next = C_NODE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### src/limit_order_book_matcher.sv
// A submit loads, then for each fill scans the opposite side for the best level, reads its
// head and fills against it; a last crossing check, the choice of outcome and, for a resting
// limit order, a scan of its own side and the insert follow, then the top-of-book scan and
// final beat. A cancel walks the levels and the orders on live ones, then the same scan.
// One request at a time; output stalls hold the sequencer before each beat. Reset empties
// the book at once (level valid bits clear, no clearing pass).
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority order book with a sequencer and a book datapath.
// ----------------------------------------------------------------------------
module limit_order_book_matcher #(
    parameter int ORDER_SLOTS     = 1024,
    parameter int LEVELS_PER_SIDE = 64,
    parameter int MAX_FILLS       = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic        side,
    input  logic        mkt,
    input  logic [31:0] price,
    input  logic [31:0] qty,
    input  logic [63:0] client_order_id,
    input  logic [31:0] eng_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] fill_price,
    output logic [31:0] quantity,
    output logic [63:0] maker_client_id,
    output logic [31:0] maker_eng_id,
    output logic [31:0] maker_left,
    output logic [6:0]  num_fills,
    output logic        has_bid,
    output logic [31:0] bid_px,
    output logic        has_ask,
    output logic [31:0] ask_px,
    output logic        last
);

    import lobm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lobm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .stat(stat), .cmd(cmd));

    lobm_datapath #(
        .ORDER_SLOTS(ORDER_SLOTS),
        .LEVELS_PER_SIDE(LEVELS_PER_SIDE),
        .MAX_FILLS(MAX_FILLS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .req_type(req_type), .side(side), .mkt(mkt),
        .price(price), .qty(qty), .client_order_id(client_order_id),
        .eng_id(eng_id), .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .fill_price(fill_price), .quantity(quantity),
        .maker_client_id(maker_client_id), .maker_eng_id(maker_eng_id),
        .maker_left(maker_left), .num_fills(num_fills),
        .has_bid(has_bid), .bid_px(bid_px), .has_ask(has_ask),
        .ask_px(ask_px), .last(last));

endmodule
